// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// check on every edge outside reset
`define BCLE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// check on every edge, reset included
`define BCLE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define BCLE_ASSERT(lbl, prop)
`define BCLE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hw/rtl/bcle_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded circular list engine package
// Sizes, operation and status codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bcle_pkg;

  localparam int CAPACITY   = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 5;
  localparam int VAL_W      = 32;
  localparam int OP_W       = 3;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int IN_DATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = VAL_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_RM_FRONT = 3'd2,
    OP_RM_END   = 3'd3,
    OP_RM_POS   = 3'd4,
    OP_READ_ALL = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RESP,
    S_SH_RD,
    S_SH_WR,
    S_RD_ISS,
    S_RD_OUT
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    wr_tail;
    logic    wr_front;
    logic    head_dec;
    logic    head_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    idx_pos;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_cur;
    logic    rd_next;
    logic    sh_wr;
    logic    out_load;
    logic    out_data;
    logic    out_last;
    status_t out_st;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic pos_bad;
    logic shift_more;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/bcle_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bounded circular list engine controller
// Sequences one operation at a time: decode, store update, shift walk for
// positional removal, read-out walk, and result hand-off.
// ----------------------------------------------------------------------------
module bcle_ctrl
  import bcle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  status_t exec_st;
  logic    exec_resp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    exec_resp = 1'b1;
    exec_st   = ST_OK;
    case (sts.op)
      OP_APPEND, OP_INSERT: begin
        if (sts.full) exec_st = ST_FULL;
      end
      OP_RM_FRONT, OP_RM_END: begin
        if (sts.empty) exec_st = ST_EMPTY;
      end
      OP_RM_POS: begin
        if (sts.empty) exec_st = ST_EMPTY;
        else if (sts.pos_bad) exec_st = ST_BADPOS;
        else exec_resp = 1'b0;
      end
      OP_READ_ALL: begin
        if (sts.empty) exec_st = ST_EMPTY;
        else exec_resp = 1'b0;
      end
      default: exec_resp = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_resp) begin
          st_nxt    = exec_st;
          state_nxt = sts.out_free ? S_IDLE : S_RESP;
        end else begin
          case (sts.op)
            OP_RM_POS:   state_nxt = S_SH_RD;
            OP_READ_ALL: state_nxt = S_RD_ISS;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_RESP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_SH_RD: begin
        if (sts.shift_more) begin
          state_nxt = S_SH_WR;
        end else begin
          st_nxt    = ST_OK;
          state_nxt = S_RESP;
        end
      end
      S_SH_WR:  state_nxt = S_SH_RD;
      S_RD_ISS: state_nxt = S_RD_OUT;
      S_RD_OUT: begin
        if (sts.out_free) state_nxt = sts.rd_last ? S_IDLE : S_RD_ISS;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.out_st = ST_OK;
    in_tready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready    = 1'b1;
        cmd.latch_in = in_tvalid;
      end
      S_EXEC: begin
        case (sts.op)
          OP_APPEND: begin
            cmd.wr_tail = !sts.full;
            cmd.cnt_inc = !sts.full;
          end
          OP_INSERT: begin
            cmd.wr_front = !sts.full;
            cmd.head_dec = !sts.full;
            cmd.cnt_inc  = !sts.full;
          end
          OP_RM_FRONT: begin
            cmd.head_inc = !sts.empty;
            cmd.cnt_dec  = !sts.empty;
          end
          OP_RM_END:   cmd.cnt_dec = !sts.empty;
          OP_RM_POS:   cmd.idx_pos = !exec_resp;
          OP_READ_ALL: cmd.idx_clr = !exec_resp;
          default: ;
        endcase
        if (exec_resp && sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          cmd.out_st   = exec_st;
        end
      end
      S_RESP: begin
        cmd.out_load = sts.out_free;
        cmd.out_last = 1'b1;
        cmd.out_st   = st_r;
      end
      S_SH_RD: begin
        cmd.rd_next = sts.shift_more;
        cmd.cnt_dec = !sts.shift_more;
      end
      S_SH_WR: begin
        cmd.sh_wr   = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      S_RD_ISS: cmd.rd_cur = 1'b1;
      S_RD_OUT: begin
        cmd.out_load = sts.out_free;
        cmd.out_data = 1'b1;
        cmd.out_last = sts.rd_last;
        cmd.idx_inc  = sts.out_free && !sts.rd_last;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/bcle_dpath.sv =====
// ----------------------------------------------------------------------------
// Bounded circular list engine datapath
// Item registers, head, count and walk index, the entry store with its
// registered read port, and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcle_dpath
  import bcle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] h,
                                               input logic [IDX_W-1:0] k);
    logic [IDX_W:0] s;
    s = {1'b0, h} + {1'b0, k};
    if (s >= (IDX_W+1)'(CAPACITY)) s = s - (IDX_W+1)'(CAPACITY);
    return s[IDX_W-1:0];
  endfunction

  op_t              op_r;
  logic [VAL_W-1:0] val_r;
  logic [POS_W-1:0] pos_r;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] idx_p1;
  logic [CNT_W-1:0] idx_p1_c;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_r;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  logic [VAL_W-1:0] mem_wd;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]            out_st_r;
  logic                  out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r  <= op_t'(in_tuser);
      val_r <= in_tdata[VAL_W-1:0];
      pos_r <= in_tdata[VAL_W+POS_W-1:VAL_W];
    end
  end

  assign idx_p1_c = CNT_W'(idx_r) + CNT_W'(1);
  assign idx_p1   = IDX_W'(idx_p1_c);

  always_comb begin
    head_nxt = head_r;
    if (cmd.head_dec) head_nxt = slot_of(head_r, IDX_W'(CAPACITY - 1));
    else if (cmd.head_inc) head_nxt = slot_of(head_r, IDX_W'(1));
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) cnt_nxt = cnt_r + CNT_W'(1);
    else if (cmd.cnt_dec) cnt_nxt = cnt_r - CNT_W'(1);
    idx_nxt = idx_r;
    if (cmd.idx_pos) idx_nxt = IDX_W'(pos_r);
    else if (cmd.idx_clr) idx_nxt = '0;
    else if (cmd.idx_inc) idx_nxt = idx_p1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
      idx_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_comb begin
    mem_we = cmd.wr_tail || cmd.wr_front || cmd.sh_wr;
    mem_wd = val_r;
    mem_wa = slot_of(head_r, IDX_W'(cnt_r));
    if (cmd.wr_front) begin
      mem_wa = slot_of(head_r, IDX_W'(CAPACITY - 1));
    end else if (cmd.sh_wr) begin
      mem_wa = slot_of(head_r, idx_r);
      mem_wd = rdata_r;
    end
    mem_re = cmd.rd_cur || cmd.rd_next;
    mem_ra = slot_of(head_r, cmd.rd_next ? idx_p1 : idx_r);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= cmd.out_data ? rdata_r : '0;
      out_st_r   <= cmd.out_st;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    sts.op         = op_r;
    sts.empty      = (cnt_r == '0);
    sts.full       = (cnt_r == CNT_W'(CAPACITY));
    sts.pos_bad    = (CMP_W'(pos_r) >= CMP_W'(cnt_r));
    sts.shift_more = (idx_p1_c < cnt_r);
    sts.rd_last    = (idx_p1_c == cnt_r);
    sts.out_free   = !out_valid_r || out_tready;
  end

  `BCLE_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(CAPACITY))
  `BCLE_ASSERT(a_load_free, cmd.out_load |-> (!out_valid_r || out_tready))
  `BCLE_ASSERT(a_cnt_step, cmd.cnt_inc |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
  `BCLE_ASSERT(a_cnt_excl, !(cmd.cnt_inc && cmd.cnt_dec))
  `BCLE_ASSERT(a_one_write, $onehot0({cmd.wr_tail, cmd.wr_front, cmd.sh_wr}))

endmodule

// ===== hw/rtl/bounded_circular_list_engine.sv =====
// A status-only result is registered from the execute state, or from the
// response state once the output is free; new operations enter only in idle.
// Remove at position walks the store to the end, a read then a write per entry.
// Read-out issues a read, then offers each entry through the single read port.
// Reset clears head, count, controller state and output valid; store holds.
// ----------------------------------------------------------------------------
// Bounded circular list engine
// Ordered list of signed words in a circular store, with front, end and
// positional removal, front and end insertion, and in-order read-out.
// ----------------------------------------------------------------------------
module bounded_circular_list_engine
  import bcle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // item_value [31:0], position [36:32]
  input  logic [OP_W-1:0]       in_tuser,   // operation [2:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_value [31:0]
  output logic [1:0]            out_tuser,  // status [1:0]
  output logic                  out_tlast
);

  cmd_t cmd;
  sts_t sts;

  bcle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bcle_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
